FILE: src/kss_pkg.sv
// Shared types and constants for the kth smallest stream selector.
package kss_pkg;

    localparam int K_RANK_WIDTH = 5;
    localparam logic [K_RANK_WIDTH-1:0] K_RANK_RESET = 5'd1;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rep;
        logic clr;
    } t_cell_ctrl;

    // Status a cell hands to its neighbors.
    typedef struct packed {
        logic valid;
        logic gt;
    } t_link;

endpackage

FILE: src/kss_cell.sv
// One cell of the descending sorted chain that holds the kept values.
module kss_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kss_pkg::t_cell_ctrl          i_ctrl,
    input  logic                         i_first,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    input  kss_pkg::t_link               i_left,
    input  logic signed [DATA_WIDTH-1:0] i_left_value,
    input  kss_pkg::t_link               i_right,
    input  logic signed [DATA_WIDTH-1:0] i_right_value,
    output kss_pkg::t_link               o_link,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic signed [DATA_WIDTH-1:0] o_next_value
);

    logic signed [DATA_WIDTH-1:0] r_value;
    logic signed [DATA_WIDTH-1:0] n_value;
    logic                         r_valid;
    logic                         n_valid;
    logic                         w_gt;

    assign w_gt = r_valid && (r_value > i_sample);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            n_valid = r_valid | i_left.valid | i_first;
            if (!w_gt) begin
                if (i_first || i_left.gt) begin
                    n_value = i_sample;
                end else if (i_left.valid) begin
                    n_value = i_left_value;
                end
            end
        end else if (i_ctrl.rep) begin
            if (i_right.gt) begin
                n_value = i_right_value;
            end else if (i_first || w_gt) begin
                n_value = i_sample;
            end
        end
        if (i_ctrl.clr) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule

FILE: src/kth_smallest_stream_select.sv
// Top level of the kth smallest stream selector built from a chain of sorting cells.
// Throughput: one element per cycle while the result register is empty or being taken.
// A result waiting on m_axis_tready holds s_axis_tready low until that transfer happens.
// The result is registered by the tlast transfer and is valid in the next cycle.
// The next array may start in the cycle after tlast; the chain clears as tlast is taken.
// Reset clears the held count, the cell valid bits, the output valid bit, and sets k_rank to 1.
module kth_smallest_stream_select #(
    parameter int K_MAX      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [kss_pkg::K_RANK_WIDTH-1:0]        i_cfg_wdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: sample, zero padded to whole bytes.
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                    s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata: kth_value, zero padded to whole bytes.
    output logic [((DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // tuser: too_few.
    output logic                                    m_axis_tuser
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(K_MAX + 1);
    localparam int KCMP_W  = (CNT_W > kss_pkg::K_RANK_WIDTH) ? CNT_W : kss_pkg::K_RANK_WIDTH;

    logic [kss_pkg::K_RANK_WIDTH-1:0] r_k_rank;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic                             r_out_valid;
    logic signed [DATA_WIDTH-1:0]     r_kth;
    logic                             r_too_few;

    logic                             w_accept;
    logic signed [DATA_WIDTH-1:0]     w_sample;
    logic [KCMP_W-1:0]                w_k_ext;
    logic [KCMP_W-1:0]                w_k_eff;
    logic                             w_room;
    kss_pkg::t_cell_ctrl              w_ctrl;

    kss_pkg::t_link                   w_link  [K_MAX];
    logic signed [DATA_WIDTH-1:0]     w_value [K_MAX];
    logic signed [DATA_WIDTH-1:0]     w_next  [K_MAX];
    logic [K_MAX-1:0]                 w_valid_vec;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_sample      = $signed(s_axis_tdata[DATA_WIDTH-1:0]);

    assign w_k_ext = KCMP_W'(r_k_rank);
    always_comb begin
        if (r_k_rank == '0) begin
            w_k_eff = KCMP_W'(1);
        end else if (w_k_ext > KCMP_W'(K_MAX)) begin
            w_k_eff = KCMP_W'(K_MAX);
        end else begin
            w_k_eff = w_k_ext;
        end
    end

    assign w_room     = KCMP_W'(r_count) < w_k_eff;
    assign w_ctrl.ins = w_accept && w_room;
    assign w_ctrl.rep = w_accept && !w_room && w_link[0].gt;
    assign w_ctrl.clr = w_accept && s_axis_tlast;

    assign n_count = w_ctrl.ins ? r_count + CNT_W'(1) : r_count;

    genvar g;
    generate
        for (g = 0; g < K_MAX; g++) begin : g_cell
            kss_pkg::t_link               w_left;
            kss_pkg::t_link               w_right;
            logic signed [DATA_WIDTH-1:0] w_left_value;
            logic signed [DATA_WIDTH-1:0] w_right_value;

            if (g == 0) begin : g_head
                assign w_left       = '0;
                assign w_left_value = '0;
            end else begin : g_mid_l
                assign w_left       = w_link[g-1];
                assign w_left_value = w_value[g-1];
            end

            if (g == K_MAX - 1) begin : g_tail
                assign w_right       = '0;
                assign w_right_value = '0;
            end else begin : g_mid_r
                assign w_right       = w_link[g+1];
                assign w_right_value = w_value[g+1];
            end

            kss_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_first       (g == 0),
                .i_sample      (w_sample),
                .i_left        (w_left),
                .i_left_value  (w_left_value),
                .i_right       (w_right),
                .i_right_value (w_right_value),
                .o_link        (w_link[g]),
                .o_value       (w_value[g]),
                .o_next_value  (w_next[g])
            );

            assign w_valid_vec[g] = w_link[g].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_rank    <= kss_pkg::K_RANK_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_k_rank <= i_cfg_wdata;
            end
            if (w_ctrl.clr) begin
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
            if (w_ctrl.clr) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.clr) begin
            r_kth     <= w_next[0];
            r_too_few <= KCMP_W'(n_count) < w_k_eff;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'($unsigned(r_kth));
    assign m_axis_tuser  = r_too_few;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KCMP_W'(r_count) <= KCMP_W'(K_MAX))
        else $error("held count exceeds the chain length");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with the held count");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clr |=> (r_count == '0) && m_axis_tvalid)
        else $error("chain not cleared or result missing after the last transfer");

    generate
        for (g = 0; g + 1 < K_MAX; g++) begin : g_order_chk
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_link[g+1].valid |-> (w_link[g].valid && (w_value[g] >= w_value[g+1])))
                else $error("cell chain out of descending order");
        end
    endgenerate

endmodule
